FILE: sv/seg_isect_pkg.sv
package seg_isect_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
   localparam int CROSS_WIDTH = PROD_WIDTH + 1;

   localparam int POINT_COUNT  = 4;
   localparam int ORIENT_COUNT = 4;

   // point numbering
   localparam logic [1:0] PT_FIRST_START  = 2'd0;
   localparam logic [1:0] PT_FIRST_END    = 2'd1;
   localparam logic [1:0] PT_SECOND_START = 2'd2;
   localparam logic [1:0] PT_SECOND_END   = 2'd3;

   // orientation k: sign of cross(r - s, e - r)
   // k0: third point vs first segment, k1: fourth vs first,
   // k2: first vs second segment, k3: second vs second segment
   localparam logic [1:0] ORIENT_S [ORIENT_COUNT] =
      '{PT_FIRST_START, PT_FIRST_START, PT_SECOND_START, PT_SECOND_START};
   localparam logic [1:0] ORIENT_E [ORIENT_COUNT] =
      '{PT_FIRST_END, PT_FIRST_END, PT_SECOND_END, PT_SECOND_END};
   localparam logic [1:0] ORIENT_R [ORIENT_COUNT] =
      '{PT_SECOND_START, PT_SECOND_END, PT_FIRST_START, PT_FIRST_END};

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;
   typedef logic signed [CROSS_WIDTH-1:0] cross_type;

   // lexicographic compare, x first then y
   function automatic logic lex_lt(coord_type ax, coord_type ay,
                                   coord_type bx, coord_type by);
      lex_lt = (ax < bx) || ((ax == bx) && (ay < by));
   endfunction

endpackage

FILE: sv/segment_intersection_test.sv
// Channel   | Valid / stall          | Payload
// ----------+------------------------+------------------------------------------
// request   | req_valid / req_stall  | req_first_*, req_second_* (start/end x,y)
// response  | rsp_valid / rsp_stall  | rsp_intersects
//
// One request per cycle while req_stall is low; rsp_valid is registered.
// Stages: differences and lex compares, products, cross subtract, decision.
// The product/subtract pair of each orientation sets the depth.
// Synchronous reset clears the stage valid bits only.
// Stall backs up stage by stage; empty stages keep filling while stalled.
module segment_intersection_test (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  seg_isect_pkg::coord_type req_first_start_x,
   input  seg_isect_pkg::coord_type req_first_start_y,
   input  seg_isect_pkg::coord_type req_first_end_x,
   input  seg_isect_pkg::coord_type req_first_end_y,
   input  seg_isect_pkg::coord_type req_second_start_x,
   input  seg_isect_pkg::coord_type req_second_start_y,
   input  seg_isect_pkg::coord_type req_second_end_x,
   input  seg_isect_pkg::coord_type req_second_end_y,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_intersects
);

   seg_isect_pkg::coord_type px [seg_isect_pkg::POINT_COUNT];
   seg_isect_pkg::coord_type py [seg_isect_pkg::POINT_COUNT];

   logic [seg_isect_pkg::POINT_COUNT-1:0][seg_isect_pkg::POINT_COUNT-1:0] lt;
   logic [seg_isect_pkg::POINT_COUNT-1:0][seg_isect_pkg::POINT_COUNT-1:0] eq;

   // stage 1
   logic                     v1_ff;
   seg_isect_pkg::diff_type  ux_in [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::diff_type  uy_in [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::diff_type  vx_in [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::diff_type  vy_in [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::diff_type  ux_ff [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::diff_type  uy_ff [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::diff_type  vx_ff [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::diff_type  vy_ff [seg_isect_pkg::ORIENT_COUNT];
   logic                     same1_in, same1_ff;
   logic                     coll1_in, coll1_ff;

   // stage 2
   logic                     v2_ff;
   seg_isect_pkg::prod_type  pa_in [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::prod_type  pb_in [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::prod_type  pa_ff [seg_isect_pkg::ORIENT_COUNT];
   seg_isect_pkg::prod_type  pb_ff [seg_isect_pkg::ORIENT_COUNT];
   logic                     same2_ff, coll2_ff;

   // stage 3
   logic                     v3_ff;
   seg_isect_pkg::cross_type cross_res [seg_isect_pkg::ORIENT_COUNT];
   logic [seg_isect_pkg::ORIENT_COUNT-1:0] pos_in, neg_in, pos_ff, neg_ff;
   logic                     same3_ff, coll3_ff;

   // output stage
   logic                     rsp_valid_ff;
   logic                     rsp_intersects_in, rsp_intersects_ff;

   logic                     en1, en2, en3, en_out;

   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en3       = !v3_ff || en_out;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;

   assign px[0] = req_first_start_x;
   assign py[0] = req_first_start_y;
   assign px[1] = req_first_end_x;
   assign py[1] = req_first_end_y;
   assign px[2] = req_second_start_x;
   assign py[2] = req_second_start_y;
   assign px[3] = req_second_end_x;
   assign py[3] = req_second_end_y;

   // stage 1: pairwise compares, collinear overlap answer, differences
   always_comb begin
      logic [1:0] ia, ib, ic, id;
      for (int i = 0; i < seg_isect_pkg::POINT_COUNT; i++) begin
         for (int j = 0; j < seg_isect_pkg::POINT_COUNT; j++) begin
            lt[i][j] = seg_isect_pkg::lex_lt(px[i], py[i], px[j], py[j]);
            eq[i][j] = (px[i] == px[j]) && (py[i] == py[j]);
         end
      end
      same1_in = eq[seg_isect_pkg::PT_FIRST_START][seg_isect_pkg::PT_SECOND_START]
              || eq[seg_isect_pkg::PT_FIRST_START][seg_isect_pkg::PT_SECOND_END]
              || eq[seg_isect_pkg::PT_FIRST_END][seg_isect_pkg::PT_SECOND_START]
              || eq[seg_isect_pkg::PT_FIRST_END][seg_isect_pkg::PT_SECOND_END];
      if (lt[seg_isect_pkg::PT_FIRST_END][seg_isect_pkg::PT_FIRST_START]) begin
         ia = seg_isect_pkg::PT_FIRST_END;
         ib = seg_isect_pkg::PT_FIRST_START;
      end else begin
         ia = seg_isect_pkg::PT_FIRST_START;
         ib = seg_isect_pkg::PT_FIRST_END;
      end
      if (lt[seg_isect_pkg::PT_SECOND_END][seg_isect_pkg::PT_SECOND_START]) begin
         ic = seg_isect_pkg::PT_SECOND_END;
         id = seg_isect_pkg::PT_SECOND_START;
      end else begin
         ic = seg_isect_pkg::PT_SECOND_START;
         id = seg_isect_pkg::PT_SECOND_END;
      end
      coll1_in = (lt[ia][ic] && lt[ic][ib]) || (lt[ia][id] && lt[id][ib])
              || (lt[ic][ia] && lt[ia][id]) || (lt[ic][ib] && lt[ib][id]);
      for (int k = 0; k < seg_isect_pkg::ORIENT_COUNT; k++) begin
         ux_in[k] = seg_isect_pkg::diff_type'(px[seg_isect_pkg::ORIENT_R[k]])
                  - seg_isect_pkg::diff_type'(px[seg_isect_pkg::ORIENT_S[k]]);
         uy_in[k] = seg_isect_pkg::diff_type'(py[seg_isect_pkg::ORIENT_R[k]])
                  - seg_isect_pkg::diff_type'(py[seg_isect_pkg::ORIENT_S[k]]);
         vx_in[k] = seg_isect_pkg::diff_type'(px[seg_isect_pkg::ORIENT_E[k]])
                  - seg_isect_pkg::diff_type'(px[seg_isect_pkg::ORIENT_R[k]]);
         vy_in[k] = seg_isect_pkg::diff_type'(py[seg_isect_pkg::ORIENT_E[k]])
                  - seg_isect_pkg::diff_type'(py[seg_isect_pkg::ORIENT_R[k]]);
      end
   end

   // stage 2: full-width products
   always_comb begin
      for (int k = 0; k < seg_isect_pkg::ORIENT_COUNT; k++) begin
         pa_in[k] = seg_isect_pkg::prod_type'(ux_ff[k]) * seg_isect_pkg::prod_type'(vy_ff[k]);
         pb_in[k] = seg_isect_pkg::prod_type'(uy_ff[k]) * seg_isect_pkg::prod_type'(vx_ff[k]);
      end
   end

   // stage 3: cross product sign
   always_comb begin
      for (int k = 0; k < seg_isect_pkg::ORIENT_COUNT; k++) begin
         cross_res[k] = seg_isect_pkg::cross_type'(pa_ff[k])
                      - seg_isect_pkg::cross_type'(pb_ff[k]);
         neg_in[k]    = cross_res[k][seg_isect_pkg::CROSS_WIDTH-1];
         pos_in[k]    = !neg_in[k] && (cross_res[k] != '0);
      end
   end

   // decision
   always_comb begin
      if (same3_ff) begin
         rsp_intersects_in = 1'b1;
      end else if (!pos_ff[0] && !neg_ff[0] && !pos_ff[1] && !neg_ff[1]) begin
         rsp_intersects_in = coll3_ff;
      end else begin
         rsp_intersects_in = !(pos_ff[0] && pos_ff[1]) && !(neg_ff[0] && neg_ff[1])
                          && !(pos_ff[2] && pos_ff[3]) && !(neg_ff[2] && neg_ff[3]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         ux_ff    <= ux_in;
         uy_ff    <= uy_in;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         same1_ff <= same1_in;
         coll1_ff <= coll1_in;
      end
      if (en2) begin
         pa_ff    <= pa_in;
         pb_ff    <= pb_in;
         same2_ff <= same1_ff;
         coll2_ff <= coll1_ff;
      end
      if (en3) begin
         pos_ff   <= pos_in;
         neg_ff   <= neg_in;
         same3_ff <= same2_ff;
         coll3_ff <= coll2_ff;
      end
      if (en_out) begin
         rsp_intersects_ff <= rsp_intersects_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_intersects = rsp_intersects_ff;

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (v1_ff && v2_ff && v3_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled with a free pipeline slot");

   a_accept_fills_stage1: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> v1_ff)
      else $error("accepted request not captured");

   a_sign_exclusive: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> ((pos_ff & neg_ff) == '0))
      else $error("cross sign both positive and negative");

   a_shared_endpoint_yes: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && same3_ff && en_out) |=> (rsp_valid && rsp_intersects))
      else $error("shared endpoint did not report intersection");

endmodule
